@@ hw/rtl/ttpc_pkg.sv @@
// Package for the tidal turbine power curve: register codes, curve limits,
// factor selection type and the elaboration-time builder for the exponential table.
// No dependencies.
`default_nettype none

package ttpc_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_CURVE_SEL = 2'd0;
   localparam logic [1:0] CSR_DESIGN_RECIP = 2'd1;
   localparam logic [1:0] CSR_RATED_KW = 2'd2;

   // Curve model codes
   localparam logic [1:0] MODEL_CUBIC = 2'd0;
   localparam logic [1:0] MODEL_EXP = 2'd1;
   localparam logic [1:0] MODEL_LOOKUP = 2'd2;

   // Register reset values
   localparam logic [1:0] CURVE_SEL_RST = MODEL_CUBIC;
   localparam logic [15:0] DESIGN_RECIP_RST = 16'd16384;
   localparam logic [15:0] RATED_KW_RST = 16'd0;

   localparam int EXP_STEP_LOG2_DEF = 8;
   localparam int EXP_STEP_LOG2_MIN = 6;
   localparam int EXP_STEP_LOG2_MAX = 10;

   // Ratio thresholds, Q2.14
   localparam logic [15:0] RATIO_ONE = 16'd16384;
   localparam logic [15:0] CUBE_R_LOW = 16'd2458;
   localparam logic [15:0] CUBE_R_HIGH = 16'd20480;
   localparam int EXP_S_MIN = 11633;
   localparam int EXP_S_MAX = 10650;
   localparam logic [15:0] EXP_R_LOW = 16'(16384 - EXP_S_MIN);
   localparam logic [15:0] EXP_R_HIGH = 16'(16384 + EXP_S_MAX);

   // Factor one in Q0.16 and the largest output value
   localparam logic [16:0] FACTOR_ONE = 17'h10000;
   localparam logic [23:0] PRODUCTION_MAX = 24'd16776960;

   typedef enum logic [1:0] {
      FAC_ZERO,
      FAC_ONE,
      FAC_CUBE,
      FAC_ROM
   } factor_kind_type;

   // Table build constants (elaboration only)
   localparam longint unsigned Q44_ONE = 64'd1 << 44;
   localparam longint unsigned EXP_RATE_NUM = 64'd125909;
   localparam longint unsigned EXP_DEN = 64'd100000;
   localparam longint unsigned EXP_GAIN = 64'd169215;
   localparam longint unsigned EXP_OFFSET = 64'd69215 << 44;
   localparam longint unsigned ROUND_HALF = 64'd1 << 27;

   function automatic int exp_rom_size(input int step_log2);
      return (EXP_S_MIN >> (14 - step_log2)) + 1;
   endfunction

   // Shift-subtract division, used for the series term divisor
   function automatic longint unsigned udiv_u64(input longint unsigned num,
                                                input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = 64'd0;
      rem = 64'd0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= den) begin
            rem = rem - den;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // round(65536*(1.69215*exp(-1.25909*k/2^step) - 0.69215)), clamped to 0..65536
   function automatic logic [16:0] exp_rom_entry(input longint unsigned k,
                                                 input int step_log2);
      longint unsigned term;
      longint unsigned pos;
      longint unsigned neg;
      longint unsigned e;
      longint unsigned a;
      longint unsigned f;
      longint unsigned v;
      logic done;
      term = Q44_ONE;
      pos = Q44_ONE;
      neg = 64'd0;
      done = 1'b0;
      for (int n = 1; n < 64; n++) begin
         if (!done) begin
            term = (term * k) >> step_log2;
            term = term * EXP_RATE_NUM / EXP_DEN;
            term = udiv_u64(term, 64'(n));
            if (term == 64'd0) begin
               done = 1'b1;
            end else if (n[0]) begin
               neg = neg + term;
            end else begin
               pos = pos + term;
            end
         end
      end
      e = (pos > neg) ? pos - neg : 64'd0;
      a = e * EXP_GAIN;
      if (a <= EXP_OFFSET) begin
         return 17'd0;
      end
      f = (a - EXP_OFFSET) / EXP_DEN;
      v = (f + ROUND_HALF) >> 28;
      if (v > 64'd65536) begin
         v = 64'd65536;
      end
      return v[16:0];
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tidal_turbine_power_curve.sv @@
// Tidal turbine power curve: four-stage pipeline from stream speed to output power.
// Depends on ttpc_pkg and ttpc_exp_rom.
//
// Usage:
//   req channel (valid/ready) carries one signed Q3.12 stream speed per beat.
//   rsp channel (valid/ready) returns one production figure in 1/256 kW per beat,
//   in the order the speeds were taken.
//   csr port writes the curve select (index 0), the design speed reciprocal (1)
//   and the rated capacity (2); write it only while no beat is in flight.
// Pipeline: four register stages: speed x reciprocal, ratio shaping and square,
//   cube or table read, capacity multiply into the output register.
// Throughput: one beat per cycle unless rsp_ready stalls the output register;
//   each stage holds one multiplier.
// Stall: with rsp_ready low the output register holds, and earlier stages keep
//   filling their bubbles, so req_ready drops only once all four stages are full.
// Reset: clears all stage valid bits and returns the registers to curve select 0,
//   reciprocal 16384, rated capacity 0. The table is constant; no clearing pass.
`default_nettype none

module tidal_turbine_power_curve #(
   parameter int EXP_STEP_LOG2 = ttpc_pkg::EXP_STEP_LOG2_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_water_speed,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [23:0]      rsp_production,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   localparam int ROM_SIZE = ttpc_pkg::exp_rom_size(EXP_STEP_LOG2);
   localparam int K_W = $clog2(ROM_SIZE);
   localparam int K_SHIFT = 14 - EXP_STEP_LOG2;

   // Configuration registers
   logic [1:0]  curve_sel_ff;
   logic [15:0] recip_ff;
   logic [15:0] capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         curve_sel_ff <= ttpc_pkg::CURVE_SEL_RST;
         recip_ff <= ttpc_pkg::DESIGN_RECIP_RST;
         capacity_ff <= ttpc_pkg::RATED_KW_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            ttpc_pkg::CSR_CURVE_SEL: curve_sel_ff <= csr_wdata[1:0];
            ttpc_pkg::CSR_DESIGN_RECIP: recip_ff <= csr_wdata;
            ttpc_pkg::CSR_RATED_KW: capacity_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage enables: a stage advances when it is empty or its successor advances
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   logic s1_en, s2_en, s3_en, out_en;

   assign out_en = !out_valid_ff || rsp_ready;
   assign s3_en = !s3_valid_ff || out_en;
   assign s2_en = !s2_valid_ff || s3_en;
   assign s1_en = !s1_valid_ff || s2_en;
   assign req_ready = s1_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_en) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_en) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_en) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (out_en) begin
            out_valid_ff <= s3_valid_ff;
         end
      end
   end

   // Stage 1: flag non-positive speed, scale by the reciprocal
   logic        nonpos_s1_ff, nonpos_s1_in;
   logic [30:0] scaled_s1_ff, scaled_s1_in;

   assign nonpos_s1_in = req_water_speed[15] || (req_water_speed == 16'd0);
   assign scaled_s1_in = 31'(req_water_speed[14:0]) * 31'(recip_ff);

   always_ff @(posedge clock) begin
      if (s1_en) begin
         nonpos_s1_ff <= nonpos_s1_in;
         scaled_s1_ff <= scaled_s1_in;
      end
   end

   // Stage 2: saturate the ratio, pick the factor kind, square, table index
   logic [15:0]                     ratio;
   logic [29:0]                     square_full;
   logic [14:0]                     exp_diff;
   logic [14:0]                     exp_k_wide;
   ttpc_pkg::factor_kind_type       kind_s2_ff, kind_s2_in;
   logic [14:0]                     ratio_s2_ff;
   logic [14:0]                     square_s2_ff, square_s2_in;
   logic [K_W-1:0]                  k_s2_ff, k_s2_in;

   assign ratio = (|scaled_s1_ff[30:28]) ? 16'hFFFF : scaled_s1_ff[27:12];
   assign square_full = 30'(ratio[14:0]) * 30'(ratio[14:0]);
   assign square_s2_in = square_full[28:14];
   assign exp_diff = ttpc_pkg::RATIO_ONE[14:0] - ratio[14:0];
   assign exp_k_wide = exp_diff >> K_SHIFT;
   assign k_s2_in = exp_k_wide[K_W-1:0];

   always_comb begin
      kind_s2_in = ttpc_pkg::FAC_ZERO;
      if (!nonpos_s1_ff) begin
         unique case (curve_sel_ff)
            ttpc_pkg::MODEL_CUBIC: begin
               priority if (ratio < ttpc_pkg::CUBE_R_LOW || ratio > ttpc_pkg::CUBE_R_HIGH)
                  kind_s2_in = ttpc_pkg::FAC_ZERO;
               else if (ratio > ttpc_pkg::RATIO_ONE)
                  kind_s2_in = ttpc_pkg::FAC_ONE;
               else
                  kind_s2_in = ttpc_pkg::FAC_CUBE;
            end
            ttpc_pkg::MODEL_EXP: begin
               priority if (ratio < ttpc_pkg::EXP_R_LOW || ratio > ttpc_pkg::EXP_R_HIGH)
                  kind_s2_in = ttpc_pkg::FAC_ZERO;
               else if (ratio > ttpc_pkg::RATIO_ONE)
                  kind_s2_in = ttpc_pkg::FAC_ONE;
               else
                  kind_s2_in = ttpc_pkg::FAC_ROM;
            end
            default: kind_s2_in = ttpc_pkg::FAC_ZERO;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         kind_s2_ff <= kind_s2_in;
         ratio_s2_ff <= ratio[14:0];
         square_s2_ff <= square_s2_in;
         k_s2_ff <= k_s2_in;
      end
   end

   // Stage 3: zero, one, cube or table value, as a Q0.16 factor
   logic [29:0] cube_full;
   logic [16:0] rom_data;
   logic [16:0] factor_s3_ff, factor_s3_in;

   assign cube_full = 30'(square_s2_ff) * 30'(ratio_s2_ff);

   ttpc_exp_rom #(
      .STEP_LOG2(EXP_STEP_LOG2)
   ) u_exp_rom (
      .idx (k_s2_ff),
      .data(rom_data)
   );

   always_comb begin
      unique case (kind_s2_ff)
         ttpc_pkg::FAC_ZERO: factor_s3_in = 17'd0;
         ttpc_pkg::FAC_ONE:  factor_s3_in = ttpc_pkg::FACTOR_ONE;
         // Q2.14 cube to Q0.16
         ttpc_pkg::FAC_CUBE: factor_s3_in = {cube_full[28:14], 2'b00};
         ttpc_pkg::FAC_ROM:  factor_s3_in = rom_data;
         default:            factor_s3_in = 17'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (s3_en) begin
         factor_s3_ff <= factor_s3_in;
      end
   end

   // Output stage: apply capacity
   logic [32:0] power_full;
   logic [23:0] production_ff;

   assign power_full = 33'(capacity_ff) * 33'(factor_s3_ff);

   always_ff @(posedge clock) begin
      if (out_en) begin
         production_ff <= power_full[31:8];
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_production = production_ff;

`ifndef ASSERT_OFF
   a_out_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> production_ff <= ttpc_pkg::PRODUCTION_MAX)
      else $error("production above full scale");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_ready)
      else $error("input stalled with empty output stage");

   a_nonpos_zero: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_en && nonpos_s1_ff) |=> kind_s2_ff == ttpc_pkg::FAC_ZERO)
      else $error("non-positive speed gave a nonzero factor");

   a_rom_index: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && kind_s2_ff == ttpc_pkg::FAC_ROM) |-> 32'(k_s2_ff) < ROM_SIZE)
      else $error("table index out of range");

   a_out_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(s3_valid_ff))
      else $error("result appeared without a beat in stage 3");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/ttpc_exp_rom.sv @@
// Constant table of the exponential capacity factor, Q0.16, one entry per ratio step.
// Depends on ttpc_pkg for the entry builder and table size.
`default_nettype none

module ttpc_exp_rom #(
   parameter int STEP_LOG2 = ttpc_pkg::EXP_STEP_LOG2_DEF
) (
   input  wire logic [$clog2(ttpc_pkg::exp_rom_size(STEP_LOG2))-1:0] idx,
   output logic [16:0]                                                data
);

   localparam int ROM_SIZE = ttpc_pkg::exp_rom_size(STEP_LOG2);

   logic [16:0] rom_tbl [ROM_SIZE];

   for (genvar g = 0; g < ROM_SIZE; g++) begin : g_entry
      localparam logic [16:0] ENTRY = ttpc_pkg::exp_rom_entry(64'(g), STEP_LOG2);
      assign rom_tbl[g] = ENTRY;
   end

   // Indexes past the end only occur when the table is not selected
   assign data = (32'(idx) < ROM_SIZE) ? rom_tbl[idx] : 17'd0;

endmodule

`default_nettype wire
